// ----- sv/sacl_pkg.sv -----
package sacl_pkg;

   // default table depth
   localparam int SACL_TABLE_DEPTH = 64;

   // fixed protocol constants
   localparam logic [7:0]  TCP_PROTOCOL     = 8'd6;
   localparam logic [15:0] PORT_AFTER_RESET = 16'd22;

   // operation codes
   localparam logic [1:0] OP_CHECK = 2'd0;
   localparam logic [1:0] OP_BLOCK = 2'd1;
   localparam logic [1:0] OP_ALLOW = 2'd2;

   // result status codes
   localparam logic [2:0] STAT_CHECK   = 3'd0;
   localparam logic [2:0] STAT_ADDED   = 3'd1;
   localparam logic [2:0] STAT_REMOVED = 3'd2;
   localparam logic [2:0] STAT_PRESENT = 3'd3;
   localparam logic [2:0] STAT_FULL    = 3'd4;

   // configuration register indexes
   localparam logic CSR_ALLOW_MODE   = 1'b0;
   localparam logic CSR_GUARDED_PORT = 1'b1;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] address;
      logic [7:0]  protocol;
      logic [15:0] dest_port;
   } req_type;

   typedef struct packed {
      logic       accept;
      logic [2:0] update_status;
   } rsp_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic        match_en;
      logic [31:0] key;
      logic        commit_add;
      logic        commit_remove;
      logic        tag;
   } cmd_type;

   // handed from each cell to its upper neighbor
   typedef struct packed {
      logic free_seen;
      logic hit_seen;
      logic hit_allowed;
   } chain_type;

   typedef enum logic {
      ST_IDLE,
      ST_DECIDE
   } state_type;

endpackage

// ----- sv/sacl_cell.sv -----
module sacl_cell (
   input  logic                clock,
   input  logic                reset,
   input  sacl_pkg::cmd_type   cmd,
   input  sacl_pkg::chain_type chain_in,
   output sacl_pkg::chain_type chain_out
);
   import sacl_pkg::*;

   logic        valid_ff, valid_in;
   logic        allowed_ff, allowed_in;
   logic [31:0] addr_ff, addr_in;
   logic        hit_ff, hit_in;
   logic        claim;

   // this cell is the lowest free one
   assign claim = !valid_ff && !chain_in.free_seen;

   // compare, remove and fill
   always_comb begin
      valid_in   = valid_ff;
      allowed_in = allowed_ff;
      addr_in    = addr_ff;
      hit_in     = hit_ff;
      if (cmd.match_en) begin
         hit_in = valid_ff && (addr_ff == cmd.key);
      end
      if (cmd.commit_remove && hit_ff) begin
         valid_in = 1'b0;
      end
      if (cmd.commit_add && claim) begin
         valid_in   = 1'b1;
         allowed_in = cmd.tag;
         addr_in    = cmd.key;
      end
   end

   // chain toward the upper neighbor
   always_comb begin
      chain_out.free_seen   = chain_in.free_seen | !valid_ff;
      chain_out.hit_seen    = chain_in.hit_seen | hit_ff;
      chain_out.hit_allowed = chain_in.hit_allowed | (hit_ff & allowed_ff);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
      end
   end

   // entry payload
   always_ff @(posedge clock) begin
      allowed_ff <= allowed_in;
      addr_ff    <= addr_in;
   end

endmodule

// ----- sv/ssh_source_ip_acl_filter.sv -----
// an accepted item waits in the decide state while the output holds an untaken result,
//    then its result is registered; the next item is taken only after the match step
//    over all cells followed by the decide and write-back step
// a waiting result does not block the next item; it holds one item in flight
// reset (synchronous): all table entries invalid, block-list mode, guarded port 22
module ssh_source_ip_acl_filter #(
   parameter int TABLE_DEPTH = sacl_pkg::SACL_TABLE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sacl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sacl_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [15:0]       csr_wdata
);
   import sacl_pkg::*;

   state_type   state_ff, state_in;
   req_type     item_ff, item_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        mode_ff, mode_in;
   logic [15:0] port_ff, port_in;

   cmd_type     cmd;
   chain_type   chain [TABLE_DEPTH+1];
   chain_type   chain_end;

   logic        req_accept;
   logic        out_free;
   logic        is_check, is_update, want_allowed;
   logic        filtered, hit_any, hit_allowed, has_free;
   logic        verdict;
   logic [2:0]  status;
   logic        do_add, do_remove;

   // row of table cells
   assign chain[0] = '0;
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      sacl_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1])
      );
   end
   assign chain_end = chain[TABLE_DEPTH];

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // decode of the held item
   assign is_check     = (item_ff.op == OP_CHECK);
   assign is_update    = (item_ff.op == OP_BLOCK) || (item_ff.op == OP_ALLOW);
   assign want_allowed = (item_ff.op == OP_ALLOW);
   assign filtered     = (item_ff.protocol == TCP_PROTOCOL) && (item_ff.dest_port == port_ff);
   assign hit_any      = chain_end.hit_seen;
   assign hit_allowed  = chain_end.hit_allowed;
   assign has_free     = chain_end.free_seen;

   // verdict and update status
   always_comb begin
      verdict   = 1'b1;
      status    = STAT_CHECK;
      do_add    = 1'b0;
      do_remove = 1'b0;
      if (is_check) begin
         if (filtered) begin
            if (mode_ff) begin
               verdict = hit_any && hit_allowed;
            end else begin
               verdict = !(hit_any && !hit_allowed);
            end
         end
      end else if (is_update) begin
         if (hit_any) begin
            if (hit_allowed != want_allowed) begin
               status    = STAT_REMOVED;
               do_remove = 1'b1;
            end else begin
               status = STAT_PRESENT;
            end
         end else if (has_free) begin
            status = STAT_ADDED;
            do_add = 1'b1;
         end else begin
            status = STAT_FULL;
         end
      end
   end

   // broadcast to the cells
   always_comb begin
      cmd.match_en      = req_accept;
      cmd.key           = (state_ff == ST_IDLE) ? req_data.address : item_ff.address;
      cmd.commit_add    = (state_ff == ST_DECIDE) && out_free && do_add;
      cmd.commit_remove = (state_ff == ST_DECIDE) && out_free && do_remove;
      cmd.tag           = want_allowed;
   end

   // sequencer and output register
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               item_in  = req_data;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               rsp_in.accept        = verdict;
               rsp_in.update_status = status;
               rsp_valid_in         = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // configuration writes
   always_comb begin
      mode_in = mode_ff;
      port_in = port_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ALLOW_MODE:   mode_in = csr_wdata[0];
            CSR_GUARDED_PORT: port_in = csr_wdata;
            default:          mode_in = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 1'b0;
         port_ff      <= PORT_AFTER_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         port_ff      <= port_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // an accepted item moves on to the decide cycle
   a_accept_decide: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_DECIDE))
      else $error("accepted item did not reach decide");

   // decide with a free output register delivers and returns to idle
   a_decide_delivers: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DECIDE) && out_free) |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("decide did not deliver a result");

   // drops only come from packet checks
   a_drop_is_check: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.accept) |-> (rsp_ff.update_status == STAT_CHECK))
      else $error("update item dropped");

   // status code within range
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.update_status <= STAT_FULL))
      else $error("status out of range");
`endif

endmodule

// ----- dv/tb_ssh_source_ip_acl_filter.sv -----
`timescale 1ns / 100ps

module tb_ssh_source_ip_acl_filter;
   import sacl_pkg::*;

   localparam int DEPTH = SACL_TABLE_DEPTH;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int QUIET_LIMIT = 2000;
   localparam int POOL_SIZE = 100;
   localparam int PHASE_ITEMS = 150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_wdata = '0;

   // shadow copy of the filter table and its registers
   logic        shadow_valid   [DEPTH];
   logic        shadow_allowed [DEPTH];
   logic [31:0] shadow_addr    [DEPTH];
   logic        shadow_allow_mode;
   logic [15:0] shadow_port;

   rsp_type     pending_verdicts [$];
   logic [31:0] addr_pool [POOL_SIZE];
   int          mismatch_count = 0;
   int          quiet_cycles = 0;
   int          idle_gap_pct = 0;
   int          stall_pct = 0;
   bit          valid_up = 1'b0;

   ssh_source_ip_acl_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // compare each result with the oldest expected verdict
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual accept %0b status %0d",
                     $time, rsp_data.accept, rsp_data.update_status);
            mismatch_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_data.accept !== want.accept) begin
               $display("%0t: accept mismatch, expected %0b actual %0b",
                        $time, want.accept, rsp_data.accept);
               mismatch_count++;
            end
            if (rsp_data.update_status !== want.update_status) begin
               $display("%0t: update_status mismatch, expected %0d actual %0d",
                        $time, want.update_status, rsp_data.update_status);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles with no traffic on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // expected result of one item; updates the shadow table
   function automatic rsp_type filter_verdict(input req_type item);
      rsp_type verdict;
      int      hit;
      int      slot;
      logic    want_allowed;
      verdict.accept = 1'b1;
      verdict.update_status = STAT_CHECK;
      hit = -1;
      slot = -1;
      for (int i = 0; i < DEPTH; i++) begin
         if (hit < 0 && shadow_valid[i] && shadow_addr[i] == item.address) hit = i;
         if (slot < 0 && !shadow_valid[i]) slot = i;
      end
      case (item.op)
         OP_CHECK: begin
            if (item.protocol == TCP_PROTOCOL && item.dest_port == shadow_port) begin
               // a hit decides by its tag; a miss passes only in block-list mode
               if (hit >= 0) verdict.accept = shadow_allowed[hit];
               else verdict.accept = !shadow_allow_mode;
            end
         end
         OP_BLOCK, OP_ALLOW: begin
            want_allowed = (item.op == OP_ALLOW);
            if (hit >= 0) begin
               if (shadow_allowed[hit] != want_allowed) begin
                  shadow_valid[hit] = 1'b0;
                  shadow_allowed[hit] = 1'b0;
                  shadow_addr[hit] = '0;
                  verdict.update_status = STAT_REMOVED;
               end else begin
                  verdict.update_status = STAT_PRESENT;
               end
            end else if (slot < 0) begin
               verdict.update_status = STAT_FULL;
            end else begin
               shadow_valid[slot] = 1'b1;
               shadow_allowed[slot] = want_allowed;
               shadow_addr[slot] = item.address;
               verdict.update_status = STAT_ADDED;
            end
         end
         default: begin
         end
      endcase
      return verdict;
   endfunction

   // present one item, wait for acceptance, then maybe idle
   task automatic issue_request(input logic [1:0] op, input logic [31:0] address,
                                input logic [7:0] protocol, input logic [15:0] dest_port);
      req_type item;
      item.op = op;
      item.address = address;
      item.protocol = protocol;
      item.dest_port = dest_port;
      req_valid <= 1'b1;
      req_data <= item;
      valid_up = 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_verdicts.push_back(filter_verdict(item));
      if ($urandom_range(99) < idle_gap_pct) begin
         req_valid <= 1'b0;
         valid_up = 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_gap_pct);
      end
   endtask

   // lower valid and wait until every expected result is back
   task automatic drain_results();
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up = 1'b0;
      end
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write both registers while the filter is idle
   task automatic configure_filter(input logic allow_mode, input logic [15:0] port);
      drain_results();
      csr_we <= 1'b1;
      csr_index <= CSR_ALLOW_MODE;
      csr_wdata <= {15'd0, allow_mode};
      @(posedge clock);
      csr_index <= CSR_GUARDED_PORT;
      csr_wdata <= port;
      @(posedge clock);
      csr_we <= 1'b0;
      shadow_allow_mode = allow_mode;
      shadow_port = port;
   endtask

   task automatic test_reset_defaults();
      // empty table, block-list mode, port 22
      issue_request(OP_CHECK, $urandom(), TCP_PROTOCOL, PORT_AFTER_RESET);
      issue_request(OP_CHECK, 32'h0000_0000, TCP_PROTOCOL, PORT_AFTER_RESET);
      drain_results();
   endtask

   task automatic test_update_and_check();
      issue_request(OP_BLOCK, 32'h0000_0000, 8'd0, 16'd0);
      issue_request(OP_BLOCK, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
      issue_request(OP_CHECK, 32'h0000_0000, TCP_PROTOCOL, PORT_AFTER_RESET);
      issue_request(OP_CHECK, 32'hFFFF_FFFF, TCP_PROTOCOL, PORT_AFTER_RESET);
      // unfiltered packets from a blocked source
      issue_request(OP_CHECK, 32'h0000_0000, 8'd17, PORT_AFTER_RESET);
      issue_request(OP_CHECK, 32'h0000_0000, TCP_PROTOCOL, 16'd23);
      issue_request(OP_CHECK, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
      issue_request(OP_CHECK, 32'h0000_0000, 8'd0, 16'd0);
      // already present, then removal from the opposite list
      issue_request(OP_BLOCK, 32'h0000_0000, 8'd0, 16'd0);
      issue_request(OP_ALLOW, 32'h0000_0000, 8'd0, 16'd0);
      issue_request(OP_CHECK, 32'h0000_0000, TCP_PROTOCOL, PORT_AFTER_RESET);
      issue_request(OP_ALLOW, 32'h0000_0000, 8'd0, 16'd0);
      issue_request(OP_ALLOW, 32'h0000_0000, 8'd0, 16'd0);
      issue_request(OP_BLOCK, 32'h0000_0000, 8'd0, 16'd0);
      issue_request(OP_ALLOW, 32'hC0A8_0001, 8'd0, 16'd0);
      issue_request(OP_CHECK, 32'hC0A8_0001, TCP_PROTOCOL, PORT_AFTER_RESET);
      // unused op code leaves the table alone
      issue_request(OP_UNUSED, 32'hFFFF_FFFF, TCP_PROTOCOL, PORT_AFTER_RESET);
      issue_request(OP_CHECK, 32'hFFFF_FFFF, TCP_PROTOCOL, PORT_AFTER_RESET);
      // update fields beyond the address are ignored
      issue_request(OP_BLOCK, 32'hC0A8_0001, 8'hFF, 16'hFFFF);
      issue_request(OP_ALLOW, 32'hC0A8_0001, TCP_PROTOCOL, PORT_AFTER_RESET);
      drain_results();
   endtask

   task automatic test_allow_list();
      configure_filter(1'b1, 16'hFFFF);
      issue_request(OP_CHECK, 32'hFFFF_FFFF, TCP_PROTOCOL, 16'hFFFF);
      issue_request(OP_CHECK, 32'h1234_5678, TCP_PROTOCOL, 16'hFFFF);
      issue_request(OP_CHECK, 32'hC0A8_0001, TCP_PROTOCOL, 16'hFFFF);
      issue_request(OP_CHECK, 32'hFFFF_FFFF, TCP_PROTOCOL, PORT_AFTER_RESET);
      issue_request(OP_CHECK, 32'h1234_5678, 8'd7, 16'hFFFF);
      issue_request(OP_ALLOW, 32'h1234_5678, 8'd0, 16'd0);
      issue_request(OP_CHECK, 32'h1234_5678, TCP_PROTOCOL, 16'hFFFF);
      // switching back to block-list mode keeps the table
      configure_filter(1'b0, PORT_AFTER_RESET);
      issue_request(OP_CHECK, 32'hFFFF_FFFF, TCP_PROTOCOL, PORT_AFTER_RESET);
      issue_request(OP_CHECK, 32'h1234_5678, TCP_PROTOCOL, PORT_AFTER_RESET);
      drain_results();
   endtask

   task automatic test_full_table();
      int used;
      int fill;
      configure_filter(1'b0, 16'd0);
      idle_gap_pct = 51;
      used = 0;
      foreach (shadow_valid[i]) if (shadow_valid[i]) used++;
      fill = DEPTH - used;
      for (int i = 0; i < fill; i++) begin
         issue_request(OP_BLOCK, 32'h0A00_0000 + i, 8'($urandom()), 16'($urandom()));
      end
      issue_request(OP_BLOCK, 32'h0B00_0000, TCP_PROTOCOL, 16'd0);
      issue_request(OP_ALLOW, 32'h0B00_0001, TCP_PROTOCOL, 16'd0);
      issue_request(OP_BLOCK, 32'h0A00_0000, TCP_PROTOCOL, 16'd0);
      issue_request(OP_CHECK, 32'h0A00_0000, TCP_PROTOCOL, 16'd0);
      // removal still works in a full table, and frees the slots again
      for (int i = 0; i < fill; i++) begin
         issue_request(OP_ALLOW, 32'h0A00_0000 + i, 8'd0, 16'd0);
         if (i == 0) issue_request(OP_ALLOW, 32'h0B00_0001, TCP_PROTOCOL, 16'd0);
      end
      issue_request(OP_CHECK, 32'h0B00_0001, TCP_PROTOCOL, 16'd0);
      idle_gap_pct = 0;
      drain_results();
   endtask

   task automatic test_random_traffic();
      logic        modes [8];
      logic [15:0] ports [8];
      int          pick;
      logic [1:0]  op;
      logic [31:0] address;
      logic [7:0]  protocol;
      logic [15:0] dest_port;
      modes = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
      ports = '{16'd22, 16'hFFFF, 16'd0, 16'($urandom()),
                16'd22, 16'hFFFF, 16'd0, 16'($urandom())};
      foreach (addr_pool[i]) addr_pool[i] = $urandom();
      addr_pool[0] = 32'h0000_0000;
      addr_pool[1] = 32'hFFFF_FFFF;
      for (int phase = 0; phase < 8; phase++) begin
         configure_filter(modes[phase], ports[phase]);
         // idling profile cycles through none, sender, receiver, both
         case (phase % 4)
            0: begin idle_gap_pct = 0;  stall_pct = 0;  end
            1: begin idle_gap_pct = 51; stall_pct = 0;  end
            2: begin idle_gap_pct = 0;  stall_pct = 51; end
            default: begin idle_gap_pct = 6; stall_pct = 6; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(99);
            if (pick < 48) op = OP_CHECK;
            else if (pick < 72) op = OP_BLOCK;
            else if (pick < 95) op = OP_ALLOW;
            else op = OP_UNUSED;
            if ($urandom_range(3) != 0) address = addr_pool[$urandom_range(POOL_SIZE - 1)];
            else address = $urandom();
            if ($urandom_range(9) < 6) protocol = TCP_PROTOCOL;
            else protocol = 8'($urandom());
            if ($urandom_range(9) < 6) dest_port = shadow_port;
            else dest_port = 16'($urandom());
            issue_request(op, address, protocol, dest_port);
         end
      end
      idle_gap_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_allowed[i] = 1'b0;
         shadow_addr[i] = '0;
      end
      shadow_allow_mode = 1'b0;
      shadow_port = PORT_AFTER_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_update_and_check();
      test_allow_list();
      test_full_table();
      test_random_traffic();
      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/sacl_pkg.sv
sv/sacl_cell.sv
sv/ssh_source_ip_acl_filter.sv
dv/tb_ssh_source_ip_acl_filter.sv
